/* hdl/sal_pkg.sv */
// shared types and constants for the shifting array list
`timescale 1ns / 1ps
package sal_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 4;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int RD_N     = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_POS   = 3'd1,
    CMD_INS_BACK  = 3'd2,
    CMD_REM_FRONT = 3'd3,
    CMD_REM_POS   = 3'd4,
    CMD_REM_BACK  = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } op_e;

  // broadcast to every cell each cycle
  typedef struct packed {
    op_e               op;
    logic [CNT_W-1:0]  at;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] word;
  } sal_ctl_t;

endpackage

/* hdl/sal_cell.sv */
// one list slot: holds a word, loads it or takes a neighbor's word
`timescale 1ns / 1ps
module sal_cell
  import sal_pkg::*;
(
  input  logic              clk_i,
  input  logic [CNT_W-1:0]  idx_i,
  input  sal_ctl_t          ctl_i,
  input  logic [WORD_W-1:0] left_i,
  input  logic [WORD_W-1:0] right_i,
  output logic [WORD_W-1:0] data_o
);

  logic [WORD_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      OP_INS: begin
        if (idx_i == ctl_i.at) begin
          data_d = ctl_i.word;
        end else if ((idx_i > ctl_i.at) && (idx_i <= ctl_i.cnt)) begin
          data_d = left_i;
        end
      end
      OP_REM: begin
        // close the gap: take the word from above
        if ((idx_i >= ctl_i.at) && ((idx_i + CNT_W'(1)) < ctl_i.cnt)) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hdl/shifting_array_list_top.sv */
// top level of the shifting array list: command decode, cell row, read-out
`timescale 1ns / 1ps
// ordered list of up to CAPACITY signed words held in a row of cells
// usage:
//   - drive command_i, position_i, value_i and raise start; the item is
//     taken at the clock edge where start is high and busy is low
//   - busy stays low: every cell moves its word in the same cycle, so a
//     new item may be given on every clock
//   - in the cycle after the item is taken, done_o pulses for one cycle with
//     status_o, item_count_o, empty_flag_o, full_flag_o and read_value_o
//     describing the list after that item
//   - throughput 1 item per cycle; the shift of the whole row is one
//     register update, the read-out is a 16-way mux from the cell
//     registers
//   - the receiver cannot stall; each result is valid only while done_o
//     is high
//   - rejected items (full, empty, bad position) leave the list unchanged
//   - unknown commands change nothing and still give a read-out
//   - reset clears the count and the strobe; cell contents are not reset
//     and are only read below the count
module shifting_array_list_top
  import sal_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [WORD_W-1:0] value_i,
  output logic                     done_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [OCNT_W-1:0]        item_count_o,
  output logic                     empty_flag_o,
  output logic                     full_flag_o,
  output logic signed [WORD_W-1:0] read_value_o
);

  // handshake
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // list count and result registers
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q;
  status_e          status_q, status_d;
  logic [POS_W-1:0] pos_q;

  logic             is_full, is_empty;
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  sal_ctl_t         ctl;

  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);
  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(count_q);

  // decode: status, new count and the shift order for the cells
  always_comb begin
    status_d = ST_DONE;
    count_d  = count_q;
    ctl.op   = OP_NONE;
    ctl.at   = '0;
    ctl.cnt  = count_q;
    ctl.word = value_i;
    case (cmd_e'(command_i))
      CMD_INS_FRONT, CMD_INS_POS, CMD_INS_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else if ((cmd_e'(command_i) == CMD_INS_POS) && (pos_ext > cnt_ext)) begin
          status_d = ST_BADPOS;
        end else begin
          ctl.op  = OP_INS;
          count_d = count_q + CNT_W'(1);
          if (cmd_e'(command_i) == CMD_INS_BACK) begin
            ctl.at = count_q;
          end else if (cmd_e'(command_i) == CMD_INS_POS) begin
            ctl.at = CNT_W'(pos_ext);
          end
        end
      end
      CMD_REM_FRONT, CMD_REM_POS, CMD_REM_BACK: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if ((cmd_e'(command_i) == CMD_REM_POS) && (pos_ext >= cnt_ext)) begin
          status_d = ST_BADPOS;
        end else begin
          count_d = count_q - CNT_W'(1);
          // removing the last one needs no shift
          if (cmd_e'(command_i) == CMD_REM_FRONT) begin
            ctl.op = OP_REM;
          end else if (cmd_e'(command_i) == CMD_REM_POS) begin
            ctl.op = OP_REM;
            ctl.at = CNT_W'(pos_ext);
          end
        end
      end
      default: status_d = ST_DONE;
    endcase
    if (!accept) begin
      ctl.op  = OP_NONE;
      count_d = count_q;
    end
  end

  // cell row
  sal_ctl_t          ctl_cell;
  logic [WORD_W-1:0] cell_data [CAPACITY];

  assign ctl_cell = ctl;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    sal_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CNT_W'(g)),
      .ctl_i   (ctl_cell),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // payload side of the result, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pos_q    <= position_i;
    end
  end

  // read-out from the row after the step
  logic [WORD_W-1:0] rd_word;
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (pos_q == POS_W'(i)) begin
        rd_word = cell_data[i];
      end
    end
    if (CMP_W'(pos_q) >= CMP_W'(count_q)) begin
      rd_word = '0;
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign item_count_o = OCNT_W'(count_q);
  assign empty_flag_o = is_empty;
  assign full_flag_o  = is_full;
  assign read_value_o = rd_word;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result strobe");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && ctl.op == OP_INS) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status_d != ST_DONE) |=> $stable(count_q))
    else $error("rejected item changed the count");
`endif

endmodule

/* tb/shifting_array_list_top_tb.sv */
// testbench for the shifting array list: directed and random list commands checked per result
`timescale 1ns / 1ps
module shifting_array_list_top_tb;
  import sal_pkg::*;

  // the two command codes the block does not decode
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // what one result of the block should look like
  typedef struct {
    status_e                  status;
    logic [OCNT_W-1:0]        cnt;
    logic                     empty;
    logic                     full;
    logic signed [WORD_W-1:0] rd;
  } list_outcome_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [WORD_W-1:0] value_i = '0;
  logic                     done_o;
  logic [STAT_W-1:0]        status_o;
  logic [OCNT_W-1:0]        item_count_o;
  logic                     empty_flag_o;
  logic                     full_flag_o;
  logic signed [WORD_W-1:0] read_value_o;

  // shadow copy of the list, updated as each item is taken
  logic signed [WORD_W-1:0] shadow_words [CAPACITY];
  int                       shadow_cnt = 0;

  list_outcome_t pending_outcomes [$];
  int            taken_cnt = 0;
  int            result_cnt = 0;
  int            fail_cnt = 0;

  shifting_array_list_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .empty_flag_o (empty_flag_o),
    .full_flag_o  (full_flag_o),
    .read_value_o (read_value_o)
  );

  always #1 clk_i = ~clk_i;

  // apply one command to the shadow list and work out the result it gives
  function automatic list_outcome_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [WORD_W-1:0] word);
    list_outcome_t res;
    int            at;
    int            i;
    res.status = ST_DONE;
    if (cmd == CMD_INS_FRONT || cmd == CMD_INS_POS || cmd == CMD_INS_BACK) begin
      // full is checked ahead of the position
      if (shadow_cnt >= CAPACITY) begin
        res.status = ST_FULL;
      end else if (cmd == CMD_INS_POS && int'(pos) > shadow_cnt) begin
        res.status = ST_BADPOS;
      end else begin
        if (cmd == CMD_INS_FRONT) at = 0;
        else if (cmd == CMD_INS_BACK) at = shadow_cnt;
        else at = int'(pos);
        for (i = shadow_cnt; i > at; i--) shadow_words[i] = shadow_words[i-1];
        shadow_words[at] = word;
        shadow_cnt++;
      end
    end else if (cmd == CMD_REM_FRONT || cmd == CMD_REM_POS || cmd == CMD_REM_BACK) begin
      // empty is checked ahead of the position
      if (shadow_cnt == 0) begin
        res.status = ST_EMPTY;
      end else if (cmd == CMD_REM_POS && int'(pos) >= shadow_cnt) begin
        res.status = ST_BADPOS;
      end else begin
        if (cmd == CMD_REM_FRONT) at = 0;
        else if (cmd == CMD_REM_BACK) at = shadow_cnt - 1;
        else at = int'(pos);
        for (i = at; i + 1 < shadow_cnt; i++) shadow_words[i] = shadow_words[i+1];
        shadow_cnt--;
      end
    end
    // spare command codes fall through with the list untouched
    res.cnt   = OCNT_W'(shadow_cnt);
    res.empty = (shadow_cnt == 0);
    res.full  = (shadow_cnt == CAPACITY);
    res.rd    = (int'(pos) < shadow_cnt) ? shadow_words[pos] : '0;
    return res;
  endfunction

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("  mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want)
      report_fail($sformatf("result %0d %s expected %0h got %0h", result_cnt, name, want, got));
  endtask

  // result checker and item capture, both sampled at the rising edge;
  // the result of the previous item is checked before this edge's item is predicted
  always @(posedge clk_i) begin : result_checker
    list_outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_outcomes.size() == 0) begin
          report_fail($sformatf("result %0d arrived with nothing expected", result_cnt));
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(status_o));
          check_field("item_count", WORD_W'(want.cnt), WORD_W'(item_count_o));
          check_field("empty_flag", WORD_W'(want.empty), WORD_W'(empty_flag_o));
          check_field("full_flag", WORD_W'(want.full), WORD_W'(full_flag_o));
          check_field("read_value", want.rd, read_value_o);
        end
        result_cnt++;
      end
      if (start && !busy) begin
        pending_outcomes.push_back(apply_list_cmd(command_i, position_i, value_i));
        taken_cnt++;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic signed [WORD_W-1:0] word);
    int seen;
    seen = taken_cnt;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= word;
    start      <= 1'b1;
    do @(negedge clk_i); while (taken_cnt == seen);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // hold the sender off until every result is back
  task automatic wait_drained();
    idle_cycles(1);
    while (pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  // removals on an empty list, spare codes, read-out past the count
  task automatic test_empty_list();
    send_item(CMD_REM_FRONT, 4'd0, '0);
    send_item(CMD_REM_POS, 4'd0, '0);
    send_item(CMD_REM_BACK, 4'd15, '0);
    send_item(CMD_SPARE_A, 4'd0, WORD_MAX);
    send_item(CMD_SPARE_B, 4'd15, WORD_MIN);
  endtask

  // positional inserts and removes at and around the count
  task automatic test_positions();
    send_item(CMD_INS_FRONT, 4'd0, WORD_MIN);
    send_item(CMD_INS_BACK, 4'd1, WORD_MAX);
    send_item(CMD_INS_POS, 4'd5, 32'sd7);     // beyond count: bad position
    send_item(CMD_INS_POS, 4'd2, -32'sd1);    // equal to count: appends
    send_item(CMD_INS_POS, 4'd1, 32'sd0);     // middle: opens a gap
    send_item(CMD_REM_POS, 4'd4, '0);         // equal to count: bad position
    send_item(CMD_REM_POS, 4'd9, '0);
    send_item(CMD_REM_POS, 4'd1, '0);
    send_item(CMD_SPARE_A, 4'd2, '0);
    send_item(CMD_REM_BACK, 4'd0, '0);
    send_item(CMD_REM_FRONT, 4'd0, '0);
  endtask

  // fill to capacity, then every insert form against a full list
  task automatic test_full_list();
    while (shadow_cnt < CAPACITY)
      send_item(CMD_INS_BACK, 4'(shadow_cnt), $urandom());
    send_item(CMD_INS_FRONT, 4'd15, $urandom());
    send_item(CMD_INS_POS, 4'd0, $urandom());
    send_item(CMD_INS_POS, 4'd15, $urandom());  // full wins over position
    send_item(CMD_INS_BACK, 4'd7, $urandom());
    send_item(CMD_SPARE_B, 4'd15, '0);
    send_item(CMD_REM_POS, 4'd15, '0);          // last slot
    send_item(CMD_INS_POS, 4'd15, WORD_MIN);    // refill at the count
  endtask

  // random commands; the lean changes every few dozen items so the count
  // sweeps between empty and full; each cycle the sender idles with the
  // given chance, so idle_pct is the share of idle cycles
  task automatic test_random_phase(input int idle_pct, input int n_items);
    int                       k;
    int                       lean;
    int                       ins_pct;
    int                       r;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    lean = 2;
    for (k = 0; k < n_items; k++) begin
      if (k % 40 == 0) lean = $urandom_range(0, 2);
      ins_pct = (lean == 0) ? 75 : (lean == 1) ? 25 : 50;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
      end else if ($urandom_range(0, 99) < ins_pct) begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_INS_FRONT;
          1: cmd = CMD_INS_POS;
          default: cmd = CMD_INS_BACK;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: cmd = CMD_REM_FRONT;
          1: cmd = CMD_REM_POS;
          default: cmd = CMD_REM_BACK;
        endcase
      end
      // mostly legal positions, some anywhere in range
      if ($urandom_range(0, 9) < 3) begin
        pos = 4'($urandom_range(0, 15));
      end else if (cmd == CMD_INS_POS) begin
        pos = 4'($urandom_range(0, (shadow_cnt > 15) ? 15 : shadow_cnt));
      end else if (shadow_cnt > 0) begin
        pos = 4'($urandom_range(0, (shadow_cnt > 16) ? 15 : shadow_cnt - 1));
      end else begin
        pos = 4'($urandom_range(0, 15));
      end
      case ($urandom_range(0, 19))
        0: word = WORD_MIN;
        1: word = WORD_MAX;
        2: word = -32'sd1;
        default: word = $urandom();
      endcase
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        idle_cycles(1);
      send_item(cmd, pos, word);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list();
    test_positions();
    test_full_list();
    wait_drained();

    // no gaps, then a sparse sender, then an occasional gap
    test_random_phase(0, 440);
    wait_drained();
    test_random_phase(68, 440);
    wait_drained();
    test_random_phase(12, 440);

    wait_drained();
    idle_cycles(4);
    if (fail_cnt == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #200000;
    $display("Verification failed");
    $finish;
  end

endmodule
